// ===== rtl/core/sj2j_pkg.sv =====
// Shared types and constants for the Shift-JIS to ISO-2022-JP encoder.
// No dependencies; imported by every module of the block.
package sj2j_pkg;

    localparam logic [7:0] ESC_CHAR    = 8'h1B;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_B        = 8'h42;

    localparam logic [7:0] LEAD1_LO    = 8'h81;
    localparam logic [7:0] LEAD1_HI    = 8'h9F;
    localparam logic [7:0] LEAD2_LO    = 8'hE0;
    localparam logic [7:0] LEAD2_HI    = 8'hEF;

    localparam logic [7:0] ROW_SPLIT   = 8'hA0;
    localparam logic [7:0] ROW_OFS_LO  = 8'h70;
    localparam logic [7:0] ROW_OFS_HI  = 8'hB0;
    localparam logic [7:0] TRAIL_SPLIT = 8'h9F;
    localparam logic [7:0] TRAIL_GAP   = 8'h7F;
    localparam logic [7:0] COL_OFS_A   = 8'h20;
    localparam logic [7:0] COL_OFS_B   = 8'h1F;
    localparam logic [7:0] COL_OFS_C   = 8'h7E;

    // One output request: optional leading escape, up to two data bytes,
    // optional trailing ESC ( B.
    typedef struct packed {
        logic       esc_pre;        // leading escape present
        logic       pre_kanji;      // 1: ESC $ B, 0: ESC ( B
        logic [1:0] n_data;         // data bytes, 0..2
        logic [7:0] d0;
        logic [7:0] d1;
        logic       orphan;         // data byte is a lone lead
        logic       esc_post;       // trailing ESC ( B
    } t_cmd;

    function automatic logic is_lead(input logic [7:0] c);
        return (c >= LEAD1_LO && c <= LEAD1_HI) || (c >= LEAD2_LO && c <= LEAD2_HI);
    endfunction

endpackage

// ===== rtl/core/sjis_to_iso2022jp_encoder.sv =====
// Shift-JIS to ISO-2022-JP encoder, top level.
// Input accepted every cycle while the request queue has room; a source byte
// passes through the queue and the back end's request register to the output.
// The back end emits one output byte per cycle while i_ready is high; an
// item holds it until its last result, so the byte sequencer sets throughput.
// Synchronous active-low reset: ASCII mode, no lead held, queue empty.
module sjis_to_iso2022jp_encoder
    import sj2j_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_orphan_lead
);

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_q_valid;
    t_cmd w_push_cmd;
    t_cmd w_q_cmd;

    sj2j_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    sj2j_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    sj2j_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_cmd       (w_q_cmd),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_orphan_lead (o_orphan_lead)
    );

endmodule

// ===== rtl/core/sj2j_front.sv =====
// Front end: accepts bytes, tracks kanji mode and held lead, and turns each
// byte into a request except a lead held in kanji mode. Depends on sj2j_pkg.
module sj2j_front
    import sj2j_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic       r_kanji, n_kanji;
    logic       r_pending, n_pending;
    logic [7:0] r_held, n_held;

    logic       w_accept;
    logic       w_has_out;
    logic [7:0] w_row;
    logic [7:0] w_j1;
    logic [7:0] w_j2;
    logic       w_lead;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_lead   = is_lead(i_in_byte);

    always_comb begin
        w_row = r_held - ((r_held < ROW_SPLIT) ? ROW_OFS_LO : ROW_OFS_HI);
        w_j1  = {w_row[6:0], 1'b0} - {7'd0, (i_in_byte < TRAIL_SPLIT)};
        if (i_in_byte < TRAIL_SPLIT) begin
            w_j2 = i_in_byte - ((i_in_byte > TRAIL_GAP) ? COL_OFS_A : COL_OFS_B);
        end else begin
            w_j2 = i_in_byte - COL_OFS_C;
        end
    end

    always_comb begin
        o_cmd     = '0;
        w_has_out = 1'b1;
        n_kanji   = r_kanji;
        n_pending = r_pending;
        n_held    = r_held;
        if (r_pending) begin
            o_cmd.n_data   = 2'd2;
            o_cmd.d0       = w_j1;
            o_cmd.d1       = w_j2;
            o_cmd.esc_post = i_end_of_text && r_kanji;
            n_kanji        = r_kanji && !i_end_of_text;
            n_pending      = 1'b0;
            n_held         = 8'h00;
        end else if (w_lead && !i_end_of_text) begin
            // lead byte held; silently if already in kanji mode, else after ESC $ B
            o_cmd.esc_pre   = !r_kanji;
            o_cmd.pre_kanji = 1'b1;
            w_has_out       = !r_kanji;
            n_kanji         = 1'b1;
            n_pending       = 1'b1;
            n_held          = i_in_byte;
        end else begin
            o_cmd.esc_pre   = r_kanji;
            o_cmd.pre_kanji = 1'b0;
            o_cmd.n_data    = 2'd1;
            o_cmd.d0        = i_in_byte;
            o_cmd.orphan    = w_lead && i_end_of_text;
            n_kanji         = 1'b0;
        end
        if (i_end_of_text) begin
            n_pending = 1'b0;
            n_held    = 8'h00;
        end
    end

    assign o_push = w_accept && w_has_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kanji   <= 1'b0;
            r_pending <= 1'b0;
            r_held    <= 8'h00;
        end else if (w_accept) begin
            r_kanji   <= n_kanji;
            r_pending <= n_pending;
            r_held    <= n_held;
        end
    end

endmodule

// ===== rtl/core/sj2j_queue.sv =====
// Request queue between front and back ends, DEPTH entries of t_cmd.
// Depends on sj2j_pkg.
module sj2j_queue
    import sj2j_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a push");
`endif

endmodule

// ===== rtl/core/sj2j_back.sv =====
// Back end: expands one request into its escape and data bytes, one byte
// per cycle while i_ready is high, on the output channel. Depends on sj2j_pkg.
module sj2j_back
    import sj2j_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_orphan_lead
);

    t_cmd       r_cmd;
    logic       r_busy, n_busy;
    logic [2:0] r_idx, n_idx;

    logic [3:0] w_len;
    logic [2:0] w_pre;
    logic [2:0] w_k;
    logic [2:0] w_p;
    logic       w_last;
    logic       w_done;
    logic       w_load;

    function automatic logic [7:0] esc_byte(input logic [1:0] pos, input logic kanji);
        logic [7:0] b;
        case (pos)
            2'd0:    b = ESC_CHAR;
            2'd1:    b = kanji ? CH_DOLLAR : CH_LPAREN;
            default: b = CH_B;
        endcase
        return b;
    endfunction

    always_comb begin
        w_pre = r_cmd.esc_pre ? 3'd3 : 3'd0;
        w_len = {1'b0, w_pre} + {2'b00, r_cmd.n_data} + (r_cmd.esc_post ? 4'd3 : 4'd0);
        w_k   = r_idx - w_pre;
        w_p   = w_k - {1'b0, r_cmd.n_data};
        o_orphan_lead = 1'b0;
        if (r_idx < w_pre) begin
            o_out_byte = esc_byte(r_idx[1:0], r_cmd.pre_kanji);
        end else if (w_k < {1'b0, r_cmd.n_data}) begin
            o_out_byte    = w_k[0] ? r_cmd.d1 : r_cmd.d0;
            o_orphan_lead = r_cmd.orphan;
        end else begin
            o_out_byte = esc_byte(w_p[1:0], 1'b0);
        end
    end

    assign w_last     = ({1'b0, r_idx} == w_len - 4'd1);
    assign o_valid    = r_busy;
    assign o_run_last = w_last;
    assign w_done     = r_busy && i_ready && w_last;
    assign w_load     = (!r_busy || w_done) && i_q_valid;
    assign o_pop      = w_load;

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (w_load) begin
            n_busy = 1'b1;
            n_idx  = 3'd0;
        end else if (w_done) begin
            n_busy = 1'b0;
        end else if (r_busy && i_ready) begin
            n_idx = r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd <= i_q_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

`ifndef ASSERT_OFF
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ({1'b0, r_idx} < w_len))
        else $error("byte index past end of request");
    a_no_empty_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (w_len != 4'd0))
        else $error("empty request loaded");
    a_orphan_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && o_orphan_lead) |-> o_run_last)
        else $error("orphan lead not on last byte");
`endif

endmodule
